>>> design/nfjm_pkg.sv
// Package for the notch filter jitter monitor: shared constants, word types and
// the back-end state type.
// No dependencies; every other design file imports it.
package nfjm_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int STAMP_W  = 32;
  localparam int FILT_W   = 18;
  localparam int JIT_W    = 30;
  localparam int COUNT_W  = 32;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 112;

  // Notch coefficients in Q8, rounding offset and scaling shift
  localparam int COEF_X1   = 503;
  localparam int COEF_Y1   = 498;
  localparam int COEF_Y2   = 251;
  localparam int ROUND_OFS = 128;
  localparam int FRAC_BITS = 8;

  // Filter accumulator width; every partial sum fits comfortably
  localparam int NUM_W = 29;

  localparam logic signed [FILT_W-1:0] FILT_MAX = {1'b0, {(FILT_W-1){1'b1}}};
  localparam logic signed [FILT_W-1:0] FILT_MIN = {1'b1, {(FILT_W-1){1'b0}}};

  // Jitter rounding: (d + 4) / 8
  localparam int JIT_ROUND = 4;
  localparam int JIT_SHIFT = 3;

  // Histogram
  localparam int HIST_BINS_DEF = 64;

  // Queue between front and back ends
  localparam int QUEUE_DEPTH = 2;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_SAMPLE_PERIOD = 1'b0;  // register index, taken from paddr[2]
  localparam logic [STAMP_W-1:0] PERIOD_RESET = 32'd40000;

  // Result of the front end, without the histogram bin
  typedef struct packed {
    logic signed [FILT_W-1:0] filtered;
    logic                     jitter_valid;
    logic [JIT_W-1:0]         jitter;
  } front_word_t;

  localparam int FRONT_WORD_W = FILT_W + 1 + JIT_W;

  // Result word presented on the output channel
  typedef struct packed {
    logic signed [FILT_W-1:0] filtered;
    logic                     jitter_valid;
    logic [JIT_W-1:0]         jitter;
    logic [JIT_W-1:0]         peak_jitter;
    logic [COUNT_W-1:0]       bin_count;
  } result_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPDATE
  } back_state_t;

endpackage

>>> design/nfjm_queue.sv
// Small FIFO that decouples the front end from the back end.
// Depends on nfjm_pkg for its default word width and depth.
module nfjm_queue
  import nfjm_pkg::*;
#(
  parameter int DATA_W = FRONT_WORD_W,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              can_push,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              can_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] store [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign can_push = (count_r != CNT_W'(DEPTH));
  assign can_pop  = (count_r != '0);
  assign do_push  = push && can_push;
  assign do_pop   = pop && can_pop;
  assign pop_data = store[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/nfjm_front.sv
// Front end: accepts sample words, runs the notch filter in two steps and
// measures the sample interval jitter and its histogram bin.
// Depends on nfjm_pkg.
module nfjm_front
  import nfjm_pkg::*;
#(
  parameter int HIST_BINS = HIST_BINS_DEF,
  parameter int BIN_W     = $clog2(HIST_BINS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [STAMP_W-1:0]   sample_period,
  input  logic                 hold,        // back end still clearing the histogram
  output logic                 push,
  output front_word_t          push_word,
  output logic [BIN_W-1:0]     push_bin,
  input  logic                 can_push
);

  logic [SAMPLE_W-1:0] x0;
  logic [STAMP_W-1:0]  ts;
  logic                accept;

  // Filter state
  logic [SAMPLE_W-1:0]      in_d1_r, in_d2_r;
  logic signed [FILT_W-1:0] out_d1_r, out_d2_r;

  // Interval state
  logic               seen_first_r;
  logic [STAMP_W-1:0] last_stamp_r;

  // First step registers
  logic                    s1_valid_r;
  logic [SAMPLE_W-1:0]     s1_x0_r;
  logic signed [NUM_W-1:0] px_r, py1_r, py2_r;
  logic [STAMP_W-1:0]      diff_r;
  logic                    jv_r;

  logic signed [NUM_W-1:0] px, py1, py2;
  logic signed [NUM_W-1:0] num, num_adj;
  logic signed [NUM_W-FRAC_BITS-1:0] quot;
  logic signed [FILT_W-1:0] y;
  logic [STAMP_W-1:0]       dev;
  logic [STAMP_W:0]         dev_sum;
  logic [JIT_W-1:0]         jit;

  assign x0        = in_tdata[SAMPLE_W-1:0];
  assign ts        = in_tdata[SAMPLE_W+STAMP_W-1:SAMPLE_W];
  assign in_tready = !s1_valid_r && !hold;
  assign accept    = in_tvalid && in_tready;

  // Products against the current delay line
  always_comb begin
    px  = ((signed'(NUM_W'(x0)) + signed'(NUM_W'(in_d2_r))) <<< FRAC_BITS)
          - signed'(NUM_W'(in_d1_r)) * NUM_W'(COEF_X1);
    py1 = NUM_W'(out_d1_r) * NUM_W'(COEF_Y1);
    py2 = NUM_W'(out_d2_r) * NUM_W'(COEF_Y2);
  end

  // Sum with rounding offset, divide by 256 truncating toward zero, then saturate
  always_comb begin
    num     = px_r + py1_r - py2_r + NUM_W'(ROUND_OFS);
    num_adj = num[NUM_W-1] ? num + NUM_W'((1 << FRAC_BITS) - 1) : num;
    quot    = num_adj[NUM_W-1:FRAC_BITS];
    if (quot > (NUM_W-FRAC_BITS)'(FILT_MAX)) begin
      y = FILT_MAX;
    end else if (quot < (NUM_W-FRAC_BITS)'(FILT_MIN)) begin
      y = FILT_MIN;
    end else begin
      y = quot[FILT_W-1:0];
    end
  end

  // Jitter: rounded distance of the interval from the period, in units of 8 ticks
  always_comb begin
    dev     = (diff_r > sample_period) ? diff_r - sample_period : sample_period - diff_r;
    dev_sum = {1'b0, dev} + (STAMP_W+1)'(JIT_ROUND);
    jit     = dev_sum[STAMP_W:JIT_SHIFT];
  end

  always_comb begin
    push                   = s1_valid_r;
    push_word.filtered     = y;
    push_word.jitter_valid = jv_r;
    push_word.jitter       = jv_r ? jit : '0;
    if (!jv_r) begin
      push_bin = '0;
    end else if (jit >= JIT_W'(HIST_BINS)) begin
      push_bin = BIN_W'(HIST_BINS - 1);
    end else begin
      push_bin = jit[BIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      seen_first_r <= 1'b0;
      in_d1_r      <= '0;
      in_d2_r      <= '0;
      out_d1_r     <= '0;
      out_d2_r     <= '0;
    end else begin
      if (accept) begin
        s1_valid_r   <= 1'b1;
        seen_first_r <= 1'b1;
      end else if (s1_valid_r && can_push) begin
        s1_valid_r <= 1'b0;
        in_d2_r    <= in_d1_r;
        in_d1_r    <= s1_x0_r;
        out_d2_r   <= out_d1_r;
        out_d1_r   <= y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x0_r      <= x0;
      px_r         <= px;
      py1_r        <= py1;
      py2_r        <= py2;
      diff_r       <= ts - last_stamp_r;
      jv_r         <= seen_first_r;
      last_stamp_r <= ts;
    end
  end

endmodule

>>> design/nfjm_back.sv
// Back end: clears the histogram after reset, then for each queued word does
// the histogram read-modify-write, tracks the peak jitter and holds the result.
// Depends on nfjm_pkg.
module nfjm_back
  import nfjm_pkg::*;
#(
  parameter int HIST_BINS = HIST_BINS_DEF,
  parameter int BIN_W     = $clog2(HIST_BINS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             can_pop,
  input  front_word_t      pop_word,
  input  logic [BIN_W-1:0] pop_bin,
  output logic             pop,
  output logic             clearing,
  output logic             out_tvalid,
  input  logic             out_tready,
  output result_t          out_word
);

  back_state_t state_r, state_nxt;

  logic [COUNT_W-1:0] hist [HIST_BINS];
  logic [COUNT_W-1:0] rdata_r;
  logic [BIN_W-1:0]   clr_idx_r;
  logic               clr_last;

  front_word_t        item_r;
  logic [BIN_W-1:0]   bin_r;
  logic [JIT_W-1:0]   peak_r, peak_nxt;
  logic [COUNT_W-1:0] new_count;

  logic               out_valid_r;
  result_t            out_r;

  logic               out_load;
  logic               mem_we;
  logic [BIN_W-1:0]   mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;

  assign clr_last  = (clr_idx_r == BIN_W'(HIST_BINS - 1));
  assign new_count = rdata_r + 1'b1;
  assign peak_nxt  = (item_r.jitter_valid && item_r.jitter > peak_r) ? item_r.jitter : peak_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR:  if (clr_last) state_nxt = BK_IDLE;
      BK_IDLE:   if (can_pop) state_nxt = BK_UPDATE;
      BK_UPDATE: if (!out_valid_r || out_tready) state_nxt = BK_IDLE;
      default:   state_nxt = BK_CLEAR;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    clearing  = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = bin_r;
    mem_wdata = new_count;
    unique case (state_r)
      BK_CLEAR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
      end
      BK_IDLE: begin
        pop = can_pop;
      end
      BK_UPDATE: begin
        out_load = !out_valid_r || out_tready;
        mem_we   = out_load && item_r.jitter_valid;
      end
      default: begin
        clearing = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_idx_r   <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (out_load) begin
        peak_r      <= peak_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Histogram memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rdata_r <= hist[pop_bin];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= pop_word;
      bin_r  <= pop_bin;
    end
    if (out_load) begin
      out_r.filtered     <= item_r.filtered;
      out_r.jitter_valid <= item_r.jitter_valid;
      out_r.jitter       <= item_r.jitter;
      out_r.peak_jitter  <= peak_nxt;
      out_r.bin_count    <= item_r.jitter_valid ? new_count : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_word   = out_r;

endmodule

>>> design/notch_filter_jitter_monitor.sv
// Top level of the notch filter jitter monitor: configuration register,
// front end, queue and back end. Depends on nfjm_pkg and the nfjm_* modules.
//
// Usage:
//   in_*  : one word per ADC sample, tdata = {timestamp, sample}.
//   out_* : one word per sample, tdata = {bin_count, peak_jitter, jitter,
//           filtered}, tuser = jitter_valid.
//   cfg_* : APB register sample_period at byte address 0, reset 40000.
// A result passes from the front end step register through the queue and the
// back end item register to the output register. The front end takes no new
// sample until the last has left its step register, since the filter feedback
// closes over its two-step multiply and sum; the back end takes no new word
// until the histogram read-modify-write of its idle and update states is done.
// After reset the back end clears the histogram, one bin a cycle; in_tready
// stays low meanwhile, configuration writes are still taken. While the
// receiver stalls, the finished result waits in the output register, and the
// back end, the queue and the front end keep taking up to four more samples
// before in_tready falls.
module notch_filter_jitter_monitor
  import nfjm_pkg::*;
#(
  parameter int HIST_BINS = HIST_BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [11:0] sample, [43:12] timestamp, zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [17:0] filtered, [47:18] jitter,
                                            // [77:48] peak_jitter, [109:78] bin_count
  output logic                  out_tuser,  // [0] jitter_valid
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int BIN_W  = $clog2(HIST_BINS);
  localparam int QDATA_W = BIN_W + FRONT_WORD_W;

  logic [STAMP_W-1:0] period_r;
  logic               reg_sel;

  logic               q_push, q_can_push, q_pop, q_can_pop, clearing;
  front_word_t        f_word, b_word;
  logic [BIN_W-1:0]   f_bin, b_bin;
  logic [QDATA_W-1:0] q_out;
  result_t            res;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[CFG_ADDR_W-1] == REG_SAMPLE_PERIOD);
  assign cfg_prdata = reg_sel ? period_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      period_r <= cfg_pwdata;
    end
  end

  nfjm_front #(.HIST_BINS(HIST_BINS), .BIN_W(BIN_W)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .sample_period (period_r),
    .hold          (clearing),
    .push          (q_push),
    .push_word     (f_word),
    .push_bin      (f_bin),
    .can_push      (q_can_push)
  );

  nfjm_queue #(.DATA_W(QDATA_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_bin, f_word}),
    .can_push  (q_can_push),
    .pop       (q_pop),
    .pop_data  (q_out),
    .can_pop   (q_can_pop)
  );

  assign b_word = q_out[FRONT_WORD_W-1:0];
  assign b_bin  = q_out[QDATA_W-1:FRONT_WORD_W];

  nfjm_back #(.HIST_BINS(HIST_BINS), .BIN_W(BIN_W)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .can_pop    (q_can_pop),
    .pop_word   (b_word),
    .pop_bin    (b_bin),
    .pop        (q_pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_word   (res)
  );

  assign out_tdata = {2'b00, res.bin_count, res.peak_jitter, res.jitter, res.filtered};
  assign out_tuser = res.jitter_valid;

`ifndef SYNTHESIS
  // No sample may be taken while the histogram is being cleared.
  assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !in_tready)
    else $error("sample taken during histogram clear");

  // A word without a measured interval carries no jitter and no count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (res.jitter == '0 && res.bin_count == '0))
    else $error("first-sample word carries jitter data");

  // The peak can never be below the jitter just reported.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (res.peak_jitter >= res.jitter))
    else $error("peak jitter below current jitter");
`endif

endmodule
